[rtl/core/li2d_pkg.sv]
// Package for the two-line intersection block: coordinate format constants
// and the packed word types of the input and result channels. No dependencies.
package li2d_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point1_x;
    logic signed [COORD_WIDTH-1:0] point1_y;
    logic signed [COORD_WIDTH-1:0] dir1_x;
    logic signed [COORD_WIDTH-1:0] dir1_y;
    logic signed [COORD_WIDTH-1:0] point2_x;
    logic signed [COORD_WIDTH-1:0] point2_y;
    logic signed [COORD_WIDTH-1:0] dir2_x;
    logic signed [COORD_WIDTH-1:0] dir2_y;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] isect_x;
    logic signed [COORD_WIDTH-1:0] isect_y;
    logic                          parallel;
    logic                          saturated;
  } out_word_t;

  // Second-line data that rides along the pipeline beside the arithmetic.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] p2x;
    logic signed [COORD_WIDTH-1:0] p2y;
    logic signed [COORD_WIDTH-1:0] d2x;
    logic signed [COORD_WIDTH-1:0] d2y;
  } line2_t;

endpackage

[rtl/core/line_intersection_2d.sv]
// Top level of the two-line intersection pipeline: cross products, a
// one-bit-per-stage restoring divider and the final multiply-add. Uses li2d_pkg.
//
//  channel | ports                          | word
//  input   | in_valid, in_ready, in_data    | li2d_pkg::in_word_t
//  result  | out_valid, out_ready, out_data | li2d_pkg::out_word_t
//
// A new word is taken every cycle while in_ready is high; the divider resolves
// one quotient bit in each of its stages.
// All stages advance together while the output register is empty or being
// taken; when it is held, the whole pipeline holds and in_ready is low.
// rst_n (synchronous) clears only the valid bits.
module line_intersection_2d (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  li2d_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output li2d_pkg::out_word_t  out_data
);

  localparam int W    = li2d_pkg::COORD_WIDTH;
  localparam int F    = li2d_pkg::FRAC_BITS;
  localparam int DIF  = W + 1;
  localparam int PN   = DIF + W;
  localparam int PD   = 2 * W;
  localparam int NUMW = PN + 1;
  localparam int DENW = PD + 1;
  localparam int NW   = NUMW + F + 1;
  localparam int RW   = DENW + 1;
  localparam int CW   = (NW > DENW + W) ? NW : DENW + W;
  localparam int MW   = 2 * W + 1;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: point differences.
  logic                   v1_r;
  logic signed [DIF-1:0]  dx1_r, dy1_r;
  logic signed [W-1:0]    d1x1_r, d1y1_r;
  li2d_pkg::line2_t       l1_r;

  // Stage 2: the four products.
  logic                   v2_r;
  logic signed [PN-1:0]   pa2_r, pb2_r;
  logic signed [PD-1:0]   pc2_r, pd2_r;
  li2d_pkg::line2_t       l2_r;

  // Stage 3: numerator and denominator.
  logic                   v3_r;
  logic signed [NUMW-1:0] num3_r;
  logic signed [DENW-1:0] den3_r;
  li2d_pkg::line2_t       l3_r;

  // Stage 4: magnitudes and the rounded dividend.
  logic                   v4_r, par4_r, pneg4_r;
  logic [NW-1:0]          n4_r;
  logic [DENW-1:0]        d4_r;
  li2d_pkg::line2_t       l4_r;

  // Stage 5: overflow test and the start of the division.
  logic                   v5_r, par5_r, pneg5_r, ovf5_r;
  logic [RW-1:0]          r5_r;
  logic [W-1:0]           nlo5_r;
  logic [DENW-1:0]        d5_r;
  li2d_pkg::line2_t       l5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  logic signed [NUMW-1:0] num_abs_src;
  logic signed [DENW-1:0] den_abs_src;
  logic [NUMW-1:0]        nmag;
  logic [DENW-1:0]        dmag;
  logic [CW-1:0]          n_ext, d_shift;

  always_comb begin
    num_abs_src = num3_r[NUMW-1] ? -num3_r : num3_r;
    den_abs_src = den3_r[DENW-1] ? -den3_r : den3_r;
    nmag        = num_abs_src;
    dmag        = den_abs_src;
    n_ext       = CW'(n4_r);
    d_shift     = CW'(d4_r) << W;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r  <= DIF'(in_data.point1_x) - DIF'(in_data.point2_x);
      dy1_r  <= DIF'(in_data.point1_y) - DIF'(in_data.point2_y);
      d1x1_r <= in_data.dir1_x;
      d1y1_r <= in_data.dir1_y;
      l1_r   <= '{p2x: in_data.point2_x, p2y: in_data.point2_y,
                  d2x: in_data.dir2_x, d2y: in_data.dir2_y};

      pa2_r <= PN'(dx1_r * d1y1_r);
      pb2_r <= PN'(dy1_r * d1x1_r);
      pc2_r <= PD'(l1_r.d2x * d1y1_r);
      pd2_r <= PD'(l1_r.d2y * d1x1_r);
      l2_r  <= l1_r;

      num3_r <= NUMW'(pa2_r) - NUMW'(pb2_r);
      den3_r <= DENW'(pc2_r) - DENW'(pd2_r);
      l3_r   <= l2_r;

      par4_r  <= (den3_r == '0);
      pneg4_r <= num3_r[NUMW-1] ^ den3_r[DENW-1];
      n4_r    <= (NW'(nmag) << F) + NW'(dmag >> 1);
      d4_r    <= dmag;
      l4_r    <= l3_r;

      // A quotient of 2^W or more saturates whatever its low bits are.
      par5_r  <= par4_r;
      pneg5_r <= pneg4_r;
      ovf5_r  <= (n_ext >= d_shift);
      r5_r    <= RW'(n4_r >> W);
      nlo5_r  <= n4_r[W-1:0];
      d5_r    <= d4_r;
      l5_r    <= l4_r;
    end
  end

  // Divider: stage k resolves quotient bit W-1-k.
  logic                   dv_r   [W];
  logic                   dpar_r [W];
  logic                   dneg_r [W];
  logic                   dovf_r [W];
  logic [RW-1:0]          drem_r [W];
  logic [W-1:0]           dnlo_r [W];
  logic [W-1:0]           dq_r   [W];
  logic [DENW-1:0]        dd_r   [W];
  li2d_pkg::line2_t       dl_r   [W];

  genvar k;
  generate
    for (k = 0; k < W; k++) begin : g_div
      logic                   v_in, par_in, neg_in, ovf_in;
      logic [RW-1:0]          rem_in, rem_sh, rem_nxt;
      logic [W-1:0]           nlo_in, q_in;
      logic [DENW-1:0]        d_in;
      li2d_pkg::line2_t       l_in;
      logic                   qbit;

      if (k == 0) begin : g_first
        assign v_in   = v5_r;
        assign par_in = par5_r;
        assign neg_in = pneg5_r;
        assign ovf_in = ovf5_r;
        assign rem_in = r5_r;
        assign nlo_in = nlo5_r;
        assign q_in   = '0;
        assign d_in   = d5_r;
        assign l_in   = l5_r;
      end else begin : g_next
        assign v_in   = dv_r[k-1];
        assign par_in = dpar_r[k-1];
        assign neg_in = dneg_r[k-1];
        assign ovf_in = dovf_r[k-1];
        assign rem_in = drem_r[k-1];
        assign nlo_in = dnlo_r[k-1];
        assign q_in   = dq_r[k-1];
        assign d_in   = dd_r[k-1];
        assign l_in   = dl_r[k-1];
      end

      always_comb begin
        rem_sh  = {rem_in[RW-2:0], nlo_in[W-1]};
        qbit    = (rem_sh >= RW'(d_in));
        rem_nxt = qbit ? rem_sh - RW'(d_in) : rem_sh;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_r[k] <= 1'b0;
        end else if (en) begin
          dv_r[k] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          dpar_r[k] <= par_in;
          dneg_r[k] <= neg_in;
          dovf_r[k] <= ovf_in;
          drem_r[k] <= rem_nxt;
          dnlo_r[k] <= nlo_in << 1;
          dq_r[k]   <= {q_in[W-2:0], qbit};
          dd_r[k]   <= d_in;
          dl_r[k]   <= l_in;
        end
      end
    end
  endgenerate

  // Clamp stage, then products, then rounding and the final add.
  logic                   vq_r, parq_r, negq_r, satq_r;
  logic [W-1:0]           q_r;
  li2d_pkg::line2_t       lq_r;
  logic                   vm_r, parm_r, negm_r, satm_r;
  logic [PD-1:0]          prx_r, pry_r;
  li2d_pkg::line2_t       lm_r;
  logic                   out_v_r;
  li2d_pkg::out_word_t    out_r;

  logic [W-1:0]           limit, qlast;
  logic                   qover;
  logic [W-1:0]           magx, magy;

  always_comb begin
    qlast = dq_r[W-1];
    limit = dneg_r[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    qover = dovf_r[W-1] || (qlast > limit);
    magx  = lq_r.d2x[W-1] ? W'(-lq_r.d2x) : W'(lq_r.d2x);
    magy  = lq_r.d2y[W-1] ? W'(-lq_r.d2y) : W'(lq_r.d2y);
  end

  function automatic logic [W:0] round_mag(input logic [PD-1:0] prod);
    logic [MW-1:0] t;
    begin
      t = (MW'(prod) + (MW'(1) << (F - 1))) >> F;
      round_mag = (t > (MW'(1) << W)) ? {1'b1, {W{1'b0}}} : t[W:0];
    end
  endfunction

  // Adds a signed rounded product to the base and clamps to the coordinate range.
  function automatic logic [W:0] add_clamp(input logic signed [W-1:0] base,
                                           input logic [W:0] m,
                                           input logic neg);
    logic signed [W+1:0] s;
    logic signed [W+1:0] hi, lo;
    begin
      hi = (W+2)'({1'b0, {(W-1){1'b1}}});
      lo = -hi - (W+2)'(1);
      s  = (W+2)'(base) + (neg ? -$signed({1'b0, m}) : $signed({1'b0, m}));
      if (s > hi) begin
        add_clamp = {1'b1, hi[W-1:0]};
      end else if (s < lo) begin
        add_clamp = {1'b1, lo[W-1:0]};
      end else begin
        add_clamp = {1'b0, s[W-1:0]};
      end
    end
  endfunction

  logic [W:0] cx, cy;

  always_comb begin
    cx = add_clamp(lm_r.p2x, round_mag(prx_r), negm_r ^ lm_r.d2x[W-1]);
    cy = add_clamp(lm_r.p2y, round_mag(pry_r), negm_r ^ lm_r.d2y[W-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r    <= 1'b0;
      vm_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      vq_r    <= dv_r[W-1];
      vm_r    <= vq_r;
      out_v_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      parq_r <= dpar_r[W-1];
      negq_r <= dneg_r[W-1];
      satq_r <= qover;
      q_r    <= qover ? limit : qlast;
      lq_r   <= dl_r[W-1];

      parm_r <= parq_r;
      negm_r <= negq_r;
      satm_r <= satq_r;
      prx_r  <= PD'(q_r * magx);
      pry_r  <= PD'(q_r * magy);
      lm_r   <= lq_r;

      if (parm_r) begin
        out_r <= '{isect_x: '0, isect_y: '0, parallel: 1'b1, saturated: 1'b0};
      end else begin
        out_r <= '{isect_x: cx[W-1:0], isect_y: cy[W-1:0], parallel: 1'b0,
                   saturated: satm_r | cx[W] | cy[W]};
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
